@@ rtl/csv_line_column_checker_core_macros.svh @@
// Assertion macros for the checker file of the CSV line column checker.
`ifndef CSV_LINE_COLUMN_CHECKER_CORE_MACROS_SVH
`define CSV_LINE_COLUMN_CHECKER_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define CSVLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define CSVLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csvlc_pkg.sv @@
// Types, constants and helpers of the CSV line column checker.
`timescale 1ns / 1ps
package csvlc_pkg;

  localparam int unsigned MaxChunkDefault = 8191;
  localparam int unsigned ChunkWidth      = 13;
  localparam int unsigned ColWidth        = 14;
  localparam int unsigned CountWidth      = 32;
  localparam int unsigned ShowWidth       = 16;
  localparam int unsigned TdataWidth      = 160;
  localparam int unsigned TuserWidth      = 4;

  localparam logic [ColWidth-1:0]  ColumnLimit    = 14'd8192;
  localparam logic [ShowWidth-1:0] ShowLimitReset = 16'd20;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Register index carried in paddr[2].
  localparam logic RegShowLimit = 1'b0;

  typedef enum logic [2:0] {
    CLASS_EMPTY   = 3'd0,
    CLASS_HEADER  = 3'd1,
    CLASS_VALID   = 3'd2,
    CLASS_INVALID = 3'd3,
    CLASS_END     = 3'd4
  } line_class_t;

  // What the scanner reports for the item just accepted.
  typedef struct packed {
    logic                done;      // this item closes a line or is the end marker
    logic                has_line;  // a line is present to classify
    logic                nonblank;
    logic [ColWidth-1:0] columns;
    logic                fin;
  } line_evt_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] x);
    sat_inc = (x == '1) ? x : x + 1'b1;
  endfunction

endpackage

@@ rtl/csvlc_scan.sv @@
// Per-line byte scanner: quote tracking, column count and line splitting.
`timescale 1ns / 1ps
module csvlc_scan #(
  parameter int unsigned MAX_CHUNK = csvlc_pkg::MaxChunkDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_input,
  output csvlc_pkg::line_evt_t  evt
);

  logic                                quoted_mode, quoted_mode_next;
  logic                                quote_pending, quote_pending_next;
  logic                                count_stopped, count_stopped_next;
  logic                                saw_nonblank;
  logic [csvlc_pkg::ChunkWidth-1:0]    chunk_length;
  logic [csvlc_pkg::ColWidth-1:0]      running_columns, running_columns_next;
  logic [csvlc_pkg::ChunkWidth:0]      chunk_sum;
  logic                                is_blank;
  logic                                nonblank_next;
  logic                                consumed;
  logic                                line_end;
  logic                                clear_line;

  assign chunk_sum = {1'b0, chunk_length} + 1'b1;
  assign is_blank  = (data_byte == csvlc_pkg::ChSpace) || (data_byte == csvlc_pkg::ChTab) ||
                     (data_byte == csvlc_pkg::ChLf) || (data_byte == csvlc_pkg::ChCr);
  assign nonblank_next = saw_nonblank | ~is_blank;
  assign line_end = (data_byte == csvlc_pkg::ChLf) ||
                    (chunk_sum >= (csvlc_pkg::ChunkWidth+1)'(MAX_CHUNK));

  always_comb begin
    quoted_mode_next     = quoted_mode;
    quote_pending_next   = quote_pending;
    count_stopped_next   = count_stopped;
    running_columns_next = running_columns;
    consumed             = 1'b0;
    if (!count_stopped) begin
      // A quote inside quotes is decided by the byte after it.
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (data_byte == csvlc_pkg::ChQuote) begin
          consumed = 1'b1;
        end else begin
          quoted_mode_next = 1'b0;
        end
      end
      if (!consumed) begin
        priority if (data_byte == csvlc_pkg::ChQuote) begin
          if (quoted_mode_next) begin
            quote_pending_next = 1'b1;
          end else begin
            quoted_mode_next = 1'b1;
          end
        end else if (data_byte == csvlc_pkg::ChComma && !quoted_mode_next) begin
          if (running_columns < csvlc_pkg::ColumnLimit) begin
            running_columns_next = running_columns + 1'b1;
          end
        end else if (data_byte == csvlc_pkg::ChLf || data_byte == csvlc_pkg::ChCr) begin
          count_stopped_next = 1'b1;
        end else begin
          count_stopped_next = count_stopped;
        end
      end
    end
  end

  always_comb begin
    evt.done     = accept && (end_of_input || line_end);
    evt.fin      = end_of_input;
    evt.has_line = end_of_input ? (chunk_length != '0) : 1'b1;
    evt.nonblank = end_of_input ? saw_nonblank : nonblank_next;
    evt.columns  = end_of_input ? running_columns : running_columns_next;
  end

  assign clear_line = accept && (end_of_input || line_end);

  always_ff @(posedge clk) begin
    if (rst || clear_line) begin
      quoted_mode     <= 1'b0;
      quote_pending   <= 1'b0;
      count_stopped   <= 1'b0;
      saw_nonblank    <= 1'b0;
      chunk_length    <= '0;
      running_columns <= csvlc_pkg::ColWidth'(1);
    end else if (accept) begin
      quoted_mode     <= quoted_mode_next;
      quote_pending   <= quote_pending_next;
      count_stopped   <= count_stopped_next;
      saw_nonblank    <= nonblank_next;
      chunk_length    <= chunk_sum[csvlc_pkg::ChunkWidth-1:0];
      running_columns <= running_columns_next;
    end
  end

endmodule

@@ rtl/csv_line_column_checker_core.sv @@
// Top level of the CSV line column checker: line classification, totals, ports.
//
//   Channel  Dir  Handshake                  Payload
//   s_*      in   s_tvalid / s_tready        tdata: text byte, tlast: end of input
//   m_*      out  m_tvalid / m_tready        tdata: line totals, tuser: class/show,
//                                            tlast: result of the end marker
//   apb      in   psel / penable / pready    show_limit at byte address 0
//
// One byte is taken per cycle while s_tready is high; its result, if any, appears on m_* in the next cycle.
// The scanner and classifier update in the cycle of acceptance, and the result
// register decouples the output side: s_tready is low only while a result waits.
// Reset is synchronous and returns all line state and totals to their start values.
// An end marker always yields one result and then clears all state but show_limit.
`timescale 1ns / 1ps
module csv_line_column_checker_core #(
  parameter int unsigned MAX_CHUNK = csvlc_pkg::MaxChunkDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // end_of_input
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] line_number, [45:32] column_count, [59:46] expected_columns,
  // [91:60] valid_total, [123:92] invalid_total, [155:124] empty_total, rest zero
  output logic [csvlc_pkg::TdataWidth-1:0]  m_tdata,
  output logic [csvlc_pkg::TuserWidth-1:0]  m_tuser,   // [2:0] line_class, [3] show_detail
  output logic                              m_tlast,   // final_result
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned CW = csvlc_pkg::CountWidth;
  localparam int unsigned KW = csvlc_pkg::ColWidth;

  logic [csvlc_pkg::ShowWidth-1:0] show_limit;
  logic                            accept;
  csvlc_pkg::line_evt_t            evt;

  logic [KW-1:0] header_width, header_width_next;
  logic [CW-1:0] lines_seen, lines_seen_next;
  logic [CW-1:0] valid_count, valid_count_next;
  logic [CW-1:0] invalid_count, invalid_count_next;
  logic [CW-1:0] empty_count, empty_count_next;
  logic [csvlc_pkg::ShowWidth-1:0] shown_count, shown_count_next;
  logic [CW-1:0] out_line;
  logic [KW-1:0] out_cols;
  logic          show;
  csvlc_pkg::line_class_t cls;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      show_limit <= csvlc_pkg::ShowLimitReset;
    end else if (psel && penable && pwrite && paddr[2] == csvlc_pkg::RegShowLimit) begin
      show_limit <= pwdata[csvlc_pkg::ShowWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == csvlc_pkg::RegShowLimit) ?
                  {{(32-csvlc_pkg::ShowWidth){1'b0}}, show_limit} : '0;

  csvlc_scan #(.MAX_CHUNK(MAX_CHUNK)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .end_of_input (s_tlast),
    .evt          (evt)
  );

  always_comb begin
    header_width_next  = header_width;
    lines_seen_next    = lines_seen;
    valid_count_next   = valid_count;
    invalid_count_next = invalid_count;
    empty_count_next   = empty_count;
    shown_count_next   = shown_count;
    show               = 1'b0;
    cls                = csvlc_pkg::CLASS_END;
    out_cols           = '0;
    if (evt.has_line) begin
      lines_seen_next = csvlc_pkg::sat_inc(lines_seen);
      out_cols        = evt.columns;
      priority if (!evt.nonblank) begin
        empty_count_next = csvlc_pkg::sat_inc(empty_count);
        cls = csvlc_pkg::CLASS_EMPTY;
      end else if (header_width == '0) begin
        header_width_next = evt.columns;
        valid_count_next  = csvlc_pkg::sat_inc(valid_count);
        cls = csvlc_pkg::CLASS_HEADER;
      end else if (evt.columns == header_width) begin
        valid_count_next = csvlc_pkg::sat_inc(valid_count);
        cls = csvlc_pkg::CLASS_VALID;
      end else begin
        invalid_count_next = csvlc_pkg::sat_inc(invalid_count);
        cls = csvlc_pkg::CLASS_INVALID;
        if (shown_count < show_limit) begin
          show             = 1'b1;
          shown_count_next = shown_count + 1'b1;
        end
      end
    end
    out_line = lines_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (evt.done && evt.fin)) begin
      header_width  <= '0;
      lines_seen    <= '0;
      valid_count   <= '0;
      invalid_count <= '0;
      empty_count   <= '0;
      shown_count   <= '0;
    end else if (evt.done) begin
      header_width  <= header_width_next;
      lines_seen    <= lines_seen_next;
      valid_count   <= valid_count_next;
      invalid_count <= invalid_count_next;
      empty_count   <= empty_count_next;
      shown_count   <= shown_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= evt.done;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      m_tdata <= {4'b0000, empty_count_next, invalid_count_next, valid_count_next,
                  header_width_next, out_cols, out_line};
      m_tuser <= {show, cls};
      m_tlast <= evt.fin;
    end
  end

endmodule

@@ rtl/csvlc_checker.sv @@
// Port-level assertions for the CSV line column checker, bound to the top level.
`timescale 1ns / 1ps
`include "csv_line_column_checker_core_macros.svh"
module csvlc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [csvlc_pkg::TdataWidth-1:0]  m_tdata,
  input logic [csvlc_pkg::TuserWidth-1:0]  m_tuser,
  input logic                              m_tlast
);

  logic [2:0] cls;
  assign cls = m_tuser[2:0];

  `CSVLC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `CSVLC_ASSERT_IMPL(a_ready_rule, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow the result register")
  `CSVLC_ASSERT_NEXT(a_end_result, clk, rst, s_tvalid && s_tready && s_tlast, m_tvalid && m_tlast, "end marker gave no final result")
  `CSVLC_ASSERT_IMPL(a_end_only, clk, rst, m_tvalid && cls == csvlc_pkg::CLASS_END, m_tlast && m_tdata[45:32] == '0 && !m_tuser[3], "end-only result malformed")
  `CSVLC_ASSERT_IMPL(a_match, clk, rst, m_tvalid && (cls == csvlc_pkg::CLASS_HEADER || cls == csvlc_pkg::CLASS_VALID), m_tdata[45:32] == m_tdata[59:46] && !m_tuser[3], "valid line does not match the header")

endmodule

bind csv_line_column_checker_core csvlc_checker u_csvlc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
